@@ src/esd_pkg.sv @@
// shared types and constants for the escaped string decoder
`timescale 1ns / 1ps
package esd_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL,
    MODE_ESCAPE,
    MODE_HEX,
    MODE_CONT,
    MODE_ERROR
  } mode_t;

  localparam logic [1:0] REG_COMMENT_CHAR = 2'd0;
  localparam logic [1:0] REG_EQUALS_CHAR  = 2'd1;
  localparam logic [1:0] REG_MULTILINE    = 2'd2;

  localparam logic [7:0] COMMENT_RESET = 8'd59;
  localparam logic [7:0] EQUALS_RESET  = 8'd61;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_BEL       = 8'h07;
  localparam logic [7:0] CH_BS        = 8'h08;
  localparam logic [7:0] CH_FF        = 8'h0C;
  localparam logic [7:0] CH_VT        = 8'h0B;
  localparam logic [7:0] CH_LOW_A     = 8'h61;
  localparam logic [7:0] CH_LOW_B     = 8'h62;
  localparam logic [7:0] CH_LOW_F     = 8'h66;
  localparam logic [7:0] CH_LOW_N     = 8'h6E;
  localparam logic [7:0] CH_LOW_R     = 8'h72;
  localparam logic [7:0] CH_LOW_T     = 8'h74;
  localparam logic [7:0] CH_LOW_V     = 8'h76;
  localparam logic [7:0] CH_LOW_X     = 8'h78;
  localparam logic [7:0] CH_UP_X      = 8'h58;

  localparam logic [23:0] MAX_CODE_POINT = 24'h10FFFF;
  localparam logic [7:0]  UTF8_CONT      = 8'h80;
  localparam logic [7:0]  UTF8_LEAD2     = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3     = 8'hE0;
  localparam logic [7:0]  UTF8_LEAD4     = 8'hF0;

  // one accepted byte after classification: up to four data beats and an end status
  typedef struct packed {
    logic [2:0]      nbytes;
    logic [3:0][7:0] bytes;
    logic            eos;
    logic            status;
  } cmd_t;

endpackage

@@ src/esd_front.sv @@
// front end: escape state machine, config registers and utf-8 encoding
`timescale 1ns / 1ps
module esd_front import esd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       end_of_string,
  output logic       push,
  output cmd_t       cmd
);

  logic [7:0]  comment_char;
  logic [7:0]  equals_char;
  logic        multiline_allowed;
  mode_t       mode, mode_step, mode_next;
  logic [2:0]  hex_count, hex_count_step, hex_count_next;
  logic [23:0] accum, accum_step, accum_next;

  logic        is_nl;
  logic        is_blank;
  logic        raw_special;
  logic        esc_ok;
  logic [7:0]  esc_val;
  logic        esc_hex;
  logic        esc_cont;
  logic        hex_ok;
  logic [3:0]  hex_digit;
  logic [23:0] accum_shift;
  logic        hex_done;
  logic        cp_bad;
  logic [20:0] cp;
  logic [2:0]  utf_n;
  logic [3:0][7:0] utf_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      comment_char      <= COMMENT_RESET;
      equals_char       <= EQUALS_RESET;
      multiline_allowed <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_COMMENT_CHAR: comment_char      <= cfg_data;
        REG_EQUALS_CHAR:  equals_char       <= cfg_data;
        REG_MULTILINE:    multiline_allowed <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_NORMAL;
      hex_count <= 3'd0;
      accum     <= 24'd0;
    end else if (accept) begin
      mode      <= mode_next;
      hex_count <= hex_count_next;
      accum     <= accum_next;
    end
  end

  assign is_nl    = (in_byte == CH_LF) || (in_byte == CH_CR);
  assign is_blank = (in_byte == CH_SPACE) || (in_byte == CH_TAB);
  assign raw_special = (in_byte == CH_LBRACKET) || (in_byte == CH_RBRACKET) ||
                       (in_byte == CH_SQUOTE) || (in_byte == CH_DQUOTE) ||
                       (in_byte == comment_char) || (in_byte == equals_char);

  // escape mapping, register matches take priority
  always_comb begin
    esc_ok  = 1'b1;
    esc_val = in_byte;
    if (in_byte == comment_char) begin
      esc_val = comment_char;
    end else if (in_byte == equals_char) begin
      esc_val = equals_char;
    end else begin
      case (in_byte)
        CH_LOW_A: esc_val = CH_BEL;
        CH_LOW_B: esc_val = CH_BS;
        CH_LOW_F: esc_val = CH_FF;
        CH_LOW_N: esc_val = CH_LF;
        CH_LOW_R: esc_val = CH_CR;
        CH_LOW_T: esc_val = CH_TAB;
        CH_LOW_V: esc_val = CH_VT;
        CH_LBRACKET, CH_RBRACKET, CH_SQUOTE, CH_DQUOTE, CH_BACKSLASH: esc_val = in_byte;
        CH_LOW_X, CH_UP_X: esc_val = CH_LOW_X;
        CH_SPACE, CH_TAB, CH_LF, CH_CR: esc_val = CH_LF;
        default: begin
          esc_ok  = 1'b0;
          esc_val = in_byte;
        end
      endcase
    end
  end

  assign esc_hex  = (esc_val == CH_LOW_X);
  assign esc_cont = (esc_val == CH_LF) && (in_byte != CH_LOW_N);

  always_comb begin
    hex_ok    = 1'b1;
    hex_digit = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_digit = in_byte[3:0];
    end else if ((in_byte >= 8'h41 && in_byte <= 8'h46) ||
                 (in_byte >= 8'h61 && in_byte <= 8'h66)) begin
      hex_digit = in_byte[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign accum_shift = {accum[19:0], hex_digit};
  assign hex_done    = (hex_count + 3'd1) >= 3'd6;
  assign cp_bad      = accum_shift > MAX_CODE_POINT;
  assign cp          = accum_shift[20:0];

  always_comb begin
    utf_bytes = '0;
    if (cp == 21'd0) begin
      utf_n = 3'd0;
    end else if (cp <= 21'h7F) begin
      utf_n        = 3'd1;
      utf_bytes[0] = {1'b0, cp[6:0]};
    end else if (cp < 21'h800) begin
      utf_n        = 3'd2;
      utf_bytes[0] = UTF8_LEAD2 | {3'b0, cp[10:6]};
      utf_bytes[1] = UTF8_CONT | {2'b0, cp[5:0]};
    end else if (cp < 21'h10000) begin
      utf_n        = 3'd3;
      utf_bytes[0] = UTF8_LEAD3 | {4'b0, cp[15:12]};
      utf_bytes[1] = UTF8_CONT | {2'b0, cp[11:6]};
      utf_bytes[2] = UTF8_CONT | {2'b0, cp[5:0]};
    end else begin
      utf_n        = 3'd4;
      utf_bytes[0] = UTF8_LEAD4 | {5'b0, cp[20:18]};
      utf_bytes[1] = UTF8_CONT | {2'b0, cp[17:12]};
      utf_bytes[2] = UTF8_CONT | {2'b0, cp[11:6]};
      utf_bytes[3] = UTF8_CONT | {2'b0, cp[5:0]};
    end
  end

  // next state
  always_comb begin
    mode_step      = mode;
    hex_count_step = hex_count;
    accum_step     = accum;
    case (mode)
      MODE_NORMAL: begin
        if (in_byte == CH_BACKSLASH) mode_step = MODE_ESCAPE;
        else if (raw_special) mode_step = MODE_ERROR;
        else if (multiline_allowed && is_nl) mode_step = MODE_ERROR;
      end
      MODE_ESCAPE: begin
        if (!esc_ok) begin
          mode_step = MODE_ERROR;
        end else if (esc_hex) begin
          mode_step      = MODE_HEX;
          hex_count_step = 3'd0;
          accum_step     = 24'd0;
        end else if (esc_cont) begin
          if (!multiline_allowed) mode_step = MODE_ERROR;
          else mode_step = is_nl ? MODE_NORMAL : MODE_CONT;
        end else begin
          mode_step = MODE_NORMAL;
        end
      end
      MODE_HEX: begin
        if (!hex_ok) begin
          mode_step = MODE_ERROR;
        end else if (hex_done) begin
          mode_step      = cp_bad ? MODE_ERROR : MODE_NORMAL;
          hex_count_step = 3'd0;
          accum_step     = 24'd0;
        end else begin
          hex_count_step = hex_count + 3'd1;
          accum_step     = accum_shift;
        end
      end
      MODE_CONT: begin
        if (is_blank) mode_step = MODE_CONT;
        else if (is_nl) mode_step = MODE_NORMAL;
        else mode_step = MODE_ERROR;
      end
      default: mode_step = MODE_ERROR;
    endcase
  end

  assign mode_next      = end_of_string ? MODE_NORMAL : mode_step;
  assign hex_count_next = end_of_string ? 3'd0 : hex_count_step;
  assign accum_next     = end_of_string ? 24'd0 : accum_step;

  // outputs
  always_comb begin
    cmd.nbytes = 3'd0;
    cmd.bytes  = '0;
    case (mode)
      MODE_NORMAL: begin
        if (!(in_byte == CH_BACKSLASH) && !raw_special && !(multiline_allowed && is_nl)) begin
          cmd.nbytes   = 3'd1;
          cmd.bytes[0] = in_byte;
        end
      end
      MODE_ESCAPE: begin
        if (esc_ok && !esc_hex) begin
          if (esc_cont) begin
            if (multiline_allowed) begin
              cmd.nbytes   = 3'd1;
              cmd.bytes[0] = CH_LF;
            end
          end else begin
            cmd.nbytes   = 3'd1;
            cmd.bytes[0] = esc_val;
          end
        end
      end
      MODE_HEX: begin
        if (hex_ok && hex_done && !cp_bad) begin
          cmd.nbytes = utf_n;
          cmd.bytes  = utf_bytes;
        end
      end
      default: ;
    endcase
    cmd.eos    = end_of_string;
    cmd.status = end_of_string && !(mode_step == MODE_NORMAL || mode_step == MODE_CONT);
  end

  assign push = accept && ((cmd.nbytes != 3'd0) || end_of_string);

endmodule

@@ src/esd_queue.sv @@
// short command queue between front and back
`timescale 1ns / 1ps
module esd_queue import esd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop) count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

  assign head  = entries[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == CNT_W'(DEPTH));

endmodule

@@ src/esd_back.sv @@
// back end: unpacks commands into result beats behind an output register
`timescale 1ns / 1ps
module esd_back import esd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       head,
  input  logic       empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       is_data,
  output logic       status,
  output logic       last
);

  cmd_t       cur;
  logic       cur_valid;
  logic [2:0] idx;
  logic       load;
  logic       is_final;
  logic       beat_data;
  logic [2:0] total;

  assign load      = !out_valid || !out_stall;
  assign total     = cur.nbytes + {2'b0, cur.eos};
  assign is_final  = (idx + 3'd1) == total;
  assign beat_data = idx < cur.nbytes;
  assign pop       = !empty && (!cur_valid || (load && is_final));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 3'd0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
        idx       <= 3'd0;
      end else if (load && cur_valid) begin
        if (is_final) cur_valid <= 1'b0;
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= cur_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && cur_valid) begin
      out_byte <= beat_data ? cur.bytes[idx[1:0]] : 8'd0;
      is_data  <= beat_data;
      status   <= beat_data ? 1'b0 : cur.status;
      last     <= !beat_data;
    end
  end

endmodule

@@ src/escaped_string_decoder_utf8_core.sv @@
// top level of the escaped string decoder with utf-8 output
// path: commands pass the queue, the back end's cur register and the output register
// throughput: per cycle one input beat unless in_stall, one result beat unless out_stall; a
// hex code gives up to five beats for eight input beats, so the queue drains between codes
// reset (rst, synchronous): decoder state normal, registers 59/61/1, queue and output empty
`timescale 1ns / 1ps
module escaped_string_decoder_utf8_core import esd_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       end_of_string,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       is_data,
  output logic       status,
  output logic       last
);

  logic accept;
  logic push;
  cmd_t cmd;
  cmd_t head;
  logic pop;
  logic empty;
  logic full;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  esd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .accept        (accept),
    .in_byte       (in_byte),
    .end_of_string (end_of_string),
    .push          (push),
    .cmd           (cmd)
  );

  esd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  esd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .is_data   (is_data),
    .status    (status),
    .last      (last)
  );

endmodule
